/* rtl/falling_sand_grid_step_core_assert.svh */
// ----------------------------------------------------------------------------
// falling sand grid step core assertion macros
// concurrent check macros shared by the rtl, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef FALLING_SAND_GRID_STEP_CORE_ASSERT_SVH
`define FALLING_SAND_GRID_STEP_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define FSG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsg check failed");

// antecedent implies consequent in the following cycle
`define FSG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsg check failed");

`else

`define FSG_ASSERT_IMP(label, clk, rst, ante, cons)
`define FSG_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/fsg_pkg.sv */
// ----------------------------------------------------------------------------
// fsg_pkg
// shared types and constants of the falling sand grid step core
// ----------------------------------------------------------------------------
`default_nettype none

package fsg_pkg;

  // default grid size
  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 128;

  // fixed item field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 7;

  // item operation codes, code 3 does nothing
  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } fsg_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_ADV,
    ST_FINISH
  } fsg_state_t;

endpackage

`default_nettype wire

/* rtl/fsg_ram.sv */
// ----------------------------------------------------------------------------
// fsg_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fsg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/falling_sand_grid_step_core.sv */
// ----------------------------------------------------------------------------
// falling_sand_grid_step_core
// falling sand automaton on a one-bit grid held in two swapped ram buffers
// ----------------------------------------------------------------------------
`default_nettype none

// The grid of GRID_WIDTH x GRID_HEIGHT one-bit sand cells lives in two rams,
// one holding the current generation and the other receiving the next. After
// reset a clearing pass writes zero to both rams, one cell per cycle, so no
// item is accepted until the clearing pass ends. One item is worked at a time
// and each gives exactly one result item. A write (op 0) or read (op 2) goes
// through its own state and then the finish state; op 3 goes straight to the
// finish state. An advance (op 1) streams the current grid in raster order
// through the single read port of the current ram, one cell per cycle, into a
// window of two rows plus three cells, and computes every cell of the next
// grid from that window, so the next ram is written in full and needs no
// clearing. The buffers then swap roles. The result register sits between the
// two sides, so a new item is taken while a result still waits to be taken.

`include "falling_sand_grid_step_core_assert.svh"

module falling_sand_grid_step_core #(
  parameter int GRID_WIDTH  = fsg_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = fsg_pkg::GRID_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fsg_pkg::OP_W-1:0]     op,
  input  logic [fsg_pkg::COORD_W-1:0]  col,
  input  logic [fsg_pkg::COORD_W-1:0]  row,
  input  logic                         fill,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         cell_res
);

  import fsg_pkg::*;

  // sizes
  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_HEIGHT);
  // scan position runs past the grid by one row and one cell
  localparam int P_LAST = CELLS + GRID_WIDTH;
  localparam int P_W    = $clog2(CELLS + GRID_WIDTH + 2);
  localparam int WIN_LEN = 2 * GRID_WIDTH + 3;

  // window taps relative to the cell being produced, tap 0 is the newest
  localparam int T_BR = 0;
  localparam int T_B  = 1;
  localparam int T_BL = 2;
  localparam int T_R  = GRID_WIDTH;
  localparam int T_C  = GRID_WIDTH + 1;
  localparam int T_L  = GRID_WIDTH + 2;
  localparam int T_LL = GRID_WIDTH + 3;
  localparam int T_UR = 2 * GRID_WIDTH;
  localparam int T_U  = 2 * GRID_WIDTH + 1;
  localparam int T_UL = 2 * GRID_WIDTH + 2;

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

  // control state
  fsg_state_t state, state_next;
  logic       current_is_b;

  // item held while it is worked
  fsg_op_t              op_q;
  logic [COORD_W-1:0]   col_q;
  logic [COORD_W-1:0]   row_q;
  logic                 fill_q;
  logic                 inside_q;

  // scan pipeline
  logic [P_W-1:0]       p;
  logic                 s1_vld;
  logic                 s1_pad;
  logic                 s1_emit;
  logic                 s2_vld;
  logic [WIN_LEN-1:0]   win;
  logic [ADDR_W-1:0]    wr_addr;
  logic [XW-1:0]        ox;
  logic [YW-1:0]        oy;

  // ram ports
  logic                 we_a, we_b, re_a, re_b;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic                 wdata;
  logic                 rdata_a, rdata_b;
  logic                 rdata_cur;

  // misc
  logic                 in_accept;
  logic                 issue;
  logic                 adv_last;
  logic                 clear_last;
  logic                 out_load;
  logic                 in_range;
  logic [ADDR_W-1:0]    cell_addr;
  logic                 new_cell;
  logic                 here, stay, fall, from_ur, from_ul;
  logic                 x_first, x_second, x_last, y_top, y_bot;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // address checks on the incoming item
  assign in_range  = (32'(col) < GRID_WIDTH) && (32'(row) < GRID_HEIGHT);
  assign cell_addr = ADDR_W'(32'(row_q) * GRID_WIDTH + 32'(col_q));

  assign rdata_cur = current_is_b ? rdata_b : rdata_a;

  // one read of the current grid per cycle while the scan runs
  assign issue      = (state == ST_ADV) && (p <= P_W'(P_LAST));
  assign adv_last   = s2_vld && (wr_addr == ADDR_LAST);
  assign clear_last = (wr_addr == ADDR_LAST);
  assign out_load   = (state == ST_FINISH) && (!out_valid || !out_stall);

  // next grid cell from the window of the current grid
  assign x_first  = (ox == '0);
  assign x_second = (ox == XW'(1));
  assign x_last   = (ox == XW'(GRID_WIDTH - 1));
  assign y_top    = (oy == '0);
  assign y_bot    = (oy == YW'(GRID_HEIGHT - 1));
  assign here     = win[T_C];

  // grain stays: bottom row, or every allowed cell below is taken
  assign stay = here && (y_bot ||
                (win[T_B] && (x_first || win[T_BL]) && (x_last || win[T_BR])));
  // grain above drops straight in
  assign fall = !y_top && win[T_U] && !here;
  // grain above-right slides down-left, its own cell below being taken
  assign from_ur = !y_top && !x_last && win[T_UR] && win[T_R] && !here;
  // grain above-left slides down-right, straight and down-left both refused
  assign from_ul = !y_top && !x_first && win[T_UL] && win[T_L] &&
                   (x_second || win[T_LL]) && !here;
  assign new_cell = stay || fall || from_ur || from_ul;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (op)
            OP_WRITE:   state_next = ST_WRITE;
            OP_ADVANCE: state_next = ST_ADV;
            OP_READ:    state_next = ST_READ;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_WRITE: state_next = ST_FINISH;
      ST_READ:  state_next = ST_FINISH;
      ST_ADV: begin
        if (adv_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // ram controls
  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    re_a  = 1'b0;
    re_b  = 1'b0;
    waddr = wr_addr;
    raddr = p[ADDR_W-1:0];
    wdata = 1'b0;
    case (state)
      ST_CLEAR: begin
        we_a = 1'b1;
        we_b = 1'b1;
      end
      ST_WRITE: begin
        // writes outside the grid are dropped
        we_a  = inside_q && !current_is_b;
        we_b  = inside_q && current_is_b;
        waddr = cell_addr;
        wdata = fill_q;
      end
      ST_READ: begin
        re_a  = !current_is_b;
        re_b  = current_is_b;
        raddr = cell_addr;
      end
      ST_ADV: begin
        // read the current grid, write the other one
        re_a  = issue && (p < P_W'(CELLS)) && !current_is_b;
        re_b  = issue && (p < P_W'(CELLS)) && current_is_b;
        we_a  = s2_vld && current_is_b;
        we_b  = s2_vld && !current_is_b;
        wdata = new_cell;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      current_is_b <= 1'b0;
      wr_addr      <= '0;
      p            <= '0;
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_CLEAR || (state == ST_ADV && s2_vld)) begin
        wr_addr <= (wr_addr == ADDR_LAST) ? '0 : wr_addr + 1'b1;
      end

      if (in_accept) begin
        p <= '0;
      end else if (issue) begin
        p <= p + 1'b1;
      end

      s1_vld <= issue;
      s2_vld <= s1_vld && s1_emit;

      if (state == ST_ADV && adv_last) begin
        current_is_b <= !current_is_b;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q     <= fsg_op_t'(op);
      col_q    <= col;
      row_q    <= row;
      fill_q   <= fill;
      inside_q <= in_range;
      ox       <= '0;
      oy       <= '0;
    end else if (state == ST_ADV && s2_vld) begin
      if (x_last) begin
        ox <= '0;
        oy <= oy + 1'b1;
      end else begin
        ox <= ox + 1'b1;
      end
    end

    // past the last cell the stream is padded with empty cells
    s1_pad  <= (p >= P_W'(CELLS));
    s1_emit <= (p >= P_W'(GRID_WIDTH + 1));

    if (s1_vld) begin
      win <= {win[WIN_LEN-2:0], (s1_pad ? 1'b0 : rdata_cur)};
    end

    if (out_load) begin
      cell_res <= (op_q == OP_READ) && inside_q && rdata_cur;
    end
  end

  fsg_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_grid_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_a),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  fsg_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_grid_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_b),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // the current grid is never written during a generation
  `FSG_ASSERT_IMP(a_cur_untouched, clk, rst, state == ST_ADV, !(current_is_b ? we_b : we_a))

  // window cells are emitted only inside a generation
  `FSG_ASSERT_IMP(a_emit_in_scan, clk, rst, s2_vld, state == ST_ADV)

  // the last cell written swaps the buffers
  `FSG_ASSERT_NXT(a_swap_on_end, clk, rst, state == ST_ADV && adv_last, current_is_b != $past(current_is_b))

endmodule

`default_nettype wire
